@@ rtl/pvrs_pkg.sv @@
// ----------------------------------------------------------------------------
// pvrs_pkg
// Shared constants and types for the per-variable running statistics block.
// ----------------------------------------------------------------------------
package pvrs_pkg;

  localparam int NUM_VARS_DEF     = 256;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_COUNT_DEF    = 65535;

  localparam int IDX_W = 8;
  localparam int OUT_W = 16;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ADD   = 10'b0000000100,
    S_RPT   = 10'b0000001000,
    S_DIVS  = 10'b0000010000,
    S_DIVQ  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_VAR   = 10'b0010000000,
    S_SQRT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

endpackage

@@ rtl/per_variable_running_statistics_top.sv @@
// ----------------------------------------------------------------------------
// per_variable_running_statistics_top
// Table of per-variable accumulators (count, min, max, sum, sum of squares)
// held in one RAM; add requests update an entry, report requests return
// min, max, truncated mean and population standard deviation.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid, in_stall  | req_type, var_index, sample
//   out     | out_valid, out_stall| out_index, min_value, max_value,
//           |                     | mean_value, std_value, sample_count,
//           |                     | is_empty, is_constant
//
// An add reads the RAM entry, then modifies it and writes it back.
// A report runs the bit-serial divider twice (mean, then mean square) and
// then the bit-serial square root; an empty entry skips them and reports
// directly.
// After reset a clearing pass zeroes every count; input is stalled
// meanwhile. A finished report waits in the output register while
// further transfers are accepted.
// ----------------------------------------------------------------------------
module per_variable_running_statistics_top #(
  parameter int NUM_VARS     = pvrs_pkg::NUM_VARS_DEF,
  parameter int SAMPLE_WIDTH = pvrs_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_COUNT    = pvrs_pkg::MAX_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic [pvrs_pkg::IDX_W-1:0]        var_index,
  input  logic signed [pvrs_pkg::OUT_W-1:0] sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pvrs_pkg::IDX_W-1:0]        out_index,
  output logic signed [pvrs_pkg::OUT_W-1:0] min_value,
  output logic signed [pvrs_pkg::OUT_W-1:0] max_value,
  output logic signed [pvrs_pkg::OUT_W-1:0] mean_value,
  output logic [pvrs_pkg::OUT_W-1:0]        std_value,
  output logic [pvrs_pkg::OUT_W-1:0]        sample_count,
  output logic                              is_empty,
  output logic                              is_constant
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int AW   = $clog2(NUM_VARS);
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SUMW = SW + CW;
  localparam int SQW  = 2 * SW + CW;
  localparam int WW   = CW + 2 * SW + SUMW + SQW;
  localparam int OW   = pvrs_pkg::OUT_W;

  pvrs_pkg::state_t state;

  logic [AW-1:0] clr_addr;
  logic          in_fire;

  // request registers
  logic [pvrs_pkg::IDX_W-1:0] idx;
  logic [AW-1:0]              addr;
  logic                       idx_ok;
  logic signed [SW-1:0]       smp;
  logic [2*SW-1:0]            sq;

  logic signed [SW-1:0]   s_in;
  logic signed [2*SW-1:0] sq_in;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [WW-1:0] ram_rdata;

  logic [CW-1:0]          rd_n;
  logic signed [SW-1:0]   rd_min;
  logic signed [SW-1:0]   rd_max;
  logic signed [SUMW-1:0] rd_sum;
  logic [SQW-1:0]         rd_sq;

  logic signed [SW-1:0]   new_min;
  logic signed [SW-1:0]   new_max;
  logic signed [SUMW-1:0] new_sum;
  logic [SQW-1:0]         new_sq;
  logic [SUMW-1:0]        sum_mag;

  // report registers
  logic [CW-1:0]        r_n;
  logic signed [SW-1:0] r_min;
  logic signed [SW-1:0] r_max;
  logic [SQW-1:0]       r_sq;
  logic                 neg;
  logic signed [SW-1:0] mean;
  logic signed [SW-1:0] mean_next;
  logic [2*SW-1:0]      msq;
  logic [2*SW-1:0]      m2;
  logic signed [2*SW-1:0] m2_prod;
  logic [OW-1:0]        sd;

  logic           div_start;
  logic [SQW-1:0] div_dividend;
  logic [CW-1:0]  div_divisor;
  logic           div_done;
  logic [SQW-1:0] div_q;

  logic            sqrt_start;
  logic [2*SW-1:0] radicand;
  logic            sqrt_done;
  logic [SW-1:0]   root;

  logic load;
  logic empty;

  assign in_stall = (state != pvrs_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign s_in  = SW'($unsigned(sample));
  assign sq_in = s_in * s_in;

  assign rd_sq  = ram_rdata[SQW-1:0];
  assign rd_sum = ram_rdata[SQW +: SUMW];
  assign rd_max = ram_rdata[SQW + SUMW +: SW];
  assign rd_min = ram_rdata[SQW + SUMW + SW +: SW];
  assign rd_n   = ram_rdata[WW-1 -: CW];

  always_comb begin
    if (rd_n == '0) begin
      new_min = smp;
      new_max = smp;
      new_sum = SUMW'(smp);
      new_sq  = SQW'(sq);
    end else begin
      new_min = (smp < rd_min) ? smp : rd_min;
      new_max = (smp > rd_max) ? smp : rd_max;
      new_sum = rd_sum + SUMW'(smp);
      new_sq  = rd_sq + SQW'(sq);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {rd_n + CW'(1), new_min, new_max, new_sum, new_sq};
    if (state == pvrs_pkg::S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == pvrs_pkg::S_ADD) begin
      ram_we = idx_ok && (rd_n < CW'(MAX_COUNT));
    end
  end

  pvrs_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_VARS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (AW'(var_index)),
    .rdata (ram_rdata)
  );

  assign sum_mag = rd_sum[SUMW-1] ? SUMW'(-rd_sum) : SUMW'(rd_sum);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = r_sq;
    div_divisor  = r_n;
    if (state == pvrs_pkg::S_RPT) begin
      div_start    = idx_ok && (rd_n != '0);
      div_dividend = SQW'(sum_mag);
      div_divisor  = rd_n;
    end else if (state == pvrs_pkg::S_DIVS) begin
      div_start = div_done;
    end
  end

  pvrs_div #(
    .NW (SQW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mean_next  = neg ? SW'(-div_q[SW-1:0]) : SW'(div_q[SW-1:0]);
  assign m2_prod    = mean * mean;
  assign sqrt_start = (state == pvrs_pkg::S_VAR);
  assign radicand   = (msq > m2) ? (msq - m2) : '0;

  pvrs_sqrt #(
    .RTW (SW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  assign load  = (state == pvrs_pkg::S_FIN) && (!out_valid || !out_stall);
  assign empty = (r_n == '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pvrs_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        pvrs_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_VARS - 1)) begin
            state <= pvrs_pkg::S_IDLE;
          end
        end
        pvrs_pkg::S_IDLE: begin
          if (in_fire) begin
            state <= (req_type == pvrs_pkg::REQ_REPORT) ? pvrs_pkg::S_RPT : pvrs_pkg::S_ADD;
          end
        end
        pvrs_pkg::S_ADD: state <= pvrs_pkg::S_IDLE;
        pvrs_pkg::S_RPT: begin
          state <= div_start ? pvrs_pkg::S_DIVS : pvrs_pkg::S_FIN;
        end
        pvrs_pkg::S_DIVS: begin
          if (div_done) begin
            state <= pvrs_pkg::S_DIVQ;
          end
        end
        pvrs_pkg::S_DIVQ: begin
          if (div_done) begin
            state <= pvrs_pkg::S_MUL;
          end
        end
        pvrs_pkg::S_MUL:  state <= pvrs_pkg::S_VAR;
        pvrs_pkg::S_VAR:  state <= pvrs_pkg::S_SQRT;
        pvrs_pkg::S_SQRT: begin
          if (sqrt_done) begin
            state <= pvrs_pkg::S_FIN;
          end
        end
        pvrs_pkg::S_FIN: begin
          if (load) begin
            state <= pvrs_pkg::S_IDLE;
          end
        end
        default: state <= pvrs_pkg::S_CLEAR;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx    <= var_index;
      addr   <= AW'(var_index);
      idx_ok <= (32'(var_index) < 32'(NUM_VARS));
      smp    <= s_in;
      sq     <= $unsigned(sq_in);
    end
    if (state == pvrs_pkg::S_RPT) begin
      r_n   <= idx_ok ? rd_n : '0;
      r_min <= rd_min;
      r_max <= rd_max;
      r_sq  <= rd_sq;
      neg   <= rd_sum[SUMW-1];
    end
    if (state == pvrs_pkg::S_DIVS && div_done) begin
      mean <= mean_next;
    end
    if (state == pvrs_pkg::S_DIVQ && div_done) begin
      msq <= div_q[2*SW-1:0];
    end
    if (state == pvrs_pkg::S_MUL) begin
      m2 <= $unsigned(m2_prod);
    end
    if (state == pvrs_pkg::S_SQRT && sqrt_done) begin
      sd <= ((SW + OW)'(root) > (SW + OW)'(65535)) ? '1 : OW'(root);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index    <= idx;
      min_value    <= empty ? '0 : OW'(r_min);
      max_value    <= empty ? '0 : OW'(r_max);
      mean_value   <= empty ? '0 : OW'(mean);
      std_value    <= empty ? '0 : sd;
      sample_count <= OW'(r_n);
      is_empty     <= empty;
      is_constant  <= !empty && (r_min >= r_max);
    end
  end

endmodule

@@ rtl/pvrs_ram.sv @@
// ----------------------------------------------------------------------------
// pvrs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pvrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/pvrs_div.sv @@
// ----------------------------------------------------------------------------
// pvrs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvrs_div #(
  parameter int NW = 48,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dv;
  logic [NW-1:0]   quo;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial    = {rem, quo[NW-1]};
  assign ge       = trial >= {1'b0, dv};
  assign diff     = trial - {1'b0, dv};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNTW'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dv  <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

@@ rtl/pvrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// pvrs_sqrt
// Integer floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pvrs_sqrt #(
  parameter int RTW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2*RTW-1:0] radicand,
  output logic             done,
  output logic [RTW-1:0]   root
);

  localparam int CNTW = $clog2(RTW + 1);

  logic [CNTW-1:0]  cnt;
  logic [RTW+1:0]   rem;
  logic [2*RTW-1:0] x;
  logic [RTW+3:0]   t;
  logic [RTW+3:0]   trial;
  logic [RTW+3:0]   diff;
  logic             ge;

  assign t     = {rem, x[2*RTW-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = t >= trial;
  assign diff  = t - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNTW'(RTW);
      end else if (cnt != '0) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      x    <= radicand;
      root <= '0;
    end else if (cnt != '0) begin
      rem  <= ge ? diff[RTW+1:0] : t[RTW+1:0];
      x    <= {x[2*RTW-3:0], 2'b00};
      root <= {root[RTW-2:0], ge};
    end
  end

endmodule
